/* design/ps2_host_link_with_scancode_fifo_macros.svh */
// ----------------------------------------------------------------------------
// PS/2 host link assertion macros
// Shared helpers for the concurrent checks on the link's ports.
// ----------------------------------------------------------------------------
`ifndef PS2_HOST_LINK_WITH_SCANCODE_FIFO_MACROS_SVH
`define PS2_HOST_LINK_WITH_SCANCODE_FIFO_MACROS_SVH

// same-cycle implication
`define PS2HL_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PS2HL_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/ps2hl_pkg.sv */
// ----------------------------------------------------------------------------
// PS/2 host link package
// Command types, line levels, frame status codes and bit positions.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2hl_pkg;

    typedef enum logic [1:0] {
        ACT_EDGE = 2'd0,
        ACT_TICK = 2'd1,
        ACT_POP  = 2'd2,
        ACT_SEND = 2'd3
    } action_t;

    typedef struct packed {
        action_t    action;
        logic       data_bit;
        logic [7:0] send_byte;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [1:0] {
        LVL_LOW      = 2'd0,
        LVL_HIGH     = 2'd1,
        LVL_RELEASED = 2'd2
    } level_t;

    localparam logic [2:0] ST_NONE       = 3'd0;
    localparam logic [2:0] ST_STORED     = 3'd1;
    localparam logic [2:0] ST_START_ERR  = 3'd2;
    localparam logic [2:0] ST_PARITY_ERR = 3'd3;
    localparam logic [2:0] ST_STOP_ERR   = 3'd4;
    localparam logic [2:0] ST_SEND_DONE  = 3'd5;

    localparam logic [3:0] BIT_START      = 4'd1;
    localparam logic [3:0] BIT_DATA_FIRST = 4'd2;
    localparam logic [3:0] BIT_DATA_LAST  = 4'd9;
    localparam logic [3:0] BIT_PARITY     = 4'd10;
    localparam logic [3:0] BIT_STOP       = 4'd11;

    localparam logic [15:0] GAP_TIMEOUT_RESET = 16'd250;
    localparam logic [15:0] GAP_MAX           = 16'hFFFF;

    localparam int         APB_ADDR_W      = 3;
    localparam logic [0:0] REG_GAP_TIMEOUT = 1'b0;

endpackage

`default_nettype wire

/* design/ps2hl_if.sv */
// ----------------------------------------------------------------------------
// PS/2 host link channel interfaces
// Valid/ready channels for commands in and link results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ps2hl_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic       data_bit;
    logic [7:0] send_byte;

    modport source (output valid, output action, output data_bit, output send_byte,
                    input ready);
    modport sink   (input valid, input action, input data_bit, input send_byte,
                    output ready);
endinterface

interface ps2hl_rsp_if;
    logic       valid;
    logic       ready;
    logic       data_drive;
    logic       data_enable;
    logic       transmitting;
    logic [7:0] scancode;
    logic       scancode_valid;
    logic [2:0] frame_status;

    modport source (output valid, output data_drive, output data_enable,
                    output transmitting, output scancode, output scancode_valid,
                    output frame_status, input ready);
    modport sink   (input valid, input data_drive, input data_enable,
                    input transmitting, input scancode, input scancode_valid,
                    input frame_status, output ready);
endinterface

`default_nettype wire

/* design/ps2hl_front.sv */
// ----------------------------------------------------------------------------
// PS/2 host link front end
// Takes command items and classifies them for the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2hl_front (
    ps2hl_cmd_if.sink             cmd,
    input  ps2hl_pkg::q_status_t  q_status,
    output logic                  push,
    output ps2hl_pkg::cmd_t       push_cmd
);
    import ps2hl_pkg::*;

    assign cmd.ready = !q_status.full;
    assign push      = cmd.valid && !q_status.full;

    always_comb
    begin
        push_cmd.data_bit  = 1'b0;
        push_cmd.send_byte = 8'd0;
        case (cmd.action)
            ACT_EDGE:
            begin
                push_cmd.action   = ACT_EDGE;
                push_cmd.data_bit = cmd.data_bit;
            end
            ACT_TICK: push_cmd.action = ACT_TICK;
            ACT_POP:  push_cmd.action = ACT_POP;
            ACT_SEND:
            begin
                push_cmd.action    = ACT_SEND;
                push_cmd.send_byte = cmd.send_byte;
            end
            default:  push_cmd.action = ACT_TICK;
        endcase
    end

endmodule

`default_nettype wire

/* design/ps2hl_queue.sv */
// ----------------------------------------------------------------------------
// PS/2 host link command queue
// Two-entry queue between the front end and the link engine.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2hl_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ps2hl_pkg::cmd_t       push_cmd,
    input  logic                  pop,
    output ps2hl_pkg::cmd_t       head,
    output ps2hl_pkg::q_status_t  status
);
    import ps2hl_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

/* design/ps2hl_back.sv */
// ----------------------------------------------------------------------------
// PS/2 host link engine
// Frame receive and transmit, gap timer, scancode ring and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2hl_back #(
    parameter int RING_DEPTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ps2hl_pkg::cmd_t       head,
    input  ps2hl_pkg::q_status_t  q_status,
    input  logic [15:0]           gap_timeout,
    output logic                  pop,
    ps2hl_rsp_if.source           rsp
);
    import ps2hl_pkg::*;

    localparam int SLOT_W = $clog2(RING_DEPTH);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_DEPTH - 1);

    logic [3:0]            bit_index_reg, bit_index_next;
    logic [7:0]            incoming_reg, incoming_next;
    logic [7:0]            outgoing_reg, outgoing_next;
    logic                  parity_reg, parity_next;
    logic [15:0]           gap_reg, gap_next;
    logic                  rx_mode_reg, rx_mode_next;
    level_t                level_reg, level_next;
    logic [RING_DEPTH-1:0] unread_reg, unread_next;
    logic [SLOT_W-1:0]     wr_slot_reg, wr_slot_next;
    logic [SLOT_W-1:0]     rd_slot_reg, rd_slot_next;

    logic [7:0]            ring_mem [RING_DEPTH];
    logic [7:0]            mem_q;

    logic                  rsp_valid_reg;
    logic                  drive_reg, enable_reg, tx_reg, code_valid_reg;
    logic [2:0]            status_reg;

    logic                  exec;
    logic                  restart;
    logic                  wr_en, rd_en;
    logic [7:0]            wr_data;
    logic [3:0]            idx_n;
    logic [2:0]            data_pos;
    logic                  tx_bit;
    logic [2:0]            status;
    logic                  code_valid;
    logic [SLOT_W-1:0]     wr_slot_inc, rd_slot_inc;

    assign exec = !q_status.empty && (!rsp_valid_reg || rsp.ready);
    assign pop  = exec;

    assign wr_slot_inc = (wr_slot_reg == SLOT_LAST) ? '0 : wr_slot_reg + SLOT_W'(1);
    assign rd_slot_inc = (rd_slot_reg == SLOT_LAST) ? '0 : rd_slot_reg + SLOT_W'(1);

    always_comb
    begin
        bit_index_next = bit_index_reg;
        incoming_next  = incoming_reg;
        outgoing_next  = outgoing_reg;
        parity_next    = parity_reg;
        gap_next       = gap_reg;
        rx_mode_next   = rx_mode_reg;
        level_next     = level_reg;
        unread_next    = unread_reg;
        wr_slot_next   = wr_slot_reg;
        rd_slot_next   = rd_slot_reg;
        restart        = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        wr_data        = incoming_reg;
        idx_n          = 4'd0;
        data_pos       = 3'd0;
        tx_bit         = 1'b0;
        status         = ST_NONE;
        code_valid     = 1'b0;

        if (exec)
        begin
            case (head.action)
                ACT_EDGE:
                begin
                    if (rx_mode_reg)
                    begin
                        if (gap_reg > gap_timeout)
                        begin
                            bit_index_next = 4'd0;
                            incoming_next  = 8'd0;
                            outgoing_next  = 8'd0;
                            parity_next    = 1'b0;
                        end
                        gap_next       = 16'd0;
                        idx_n          = bit_index_next + 4'd1;
                        bit_index_next = idx_n;
                        data_pos       = 3'(idx_n - BIT_DATA_FIRST);
                        case (idx_n) inside
                            BIT_START:
                            begin
                                if (head.data_bit)
                                begin
                                    restart = 1'b1;
                                    status  = ST_START_ERR;
                                end
                            end
                            [BIT_DATA_FIRST:BIT_DATA_LAST]:
                            begin
                                incoming_next[data_pos] = incoming_next[data_pos]
                                                          | head.data_bit;
                                parity_next = parity_next ^ head.data_bit;
                            end
                            BIT_PARITY:
                            begin
                                if (head.data_bit == parity_next)
                                begin
                                    restart = 1'b1;
                                    status  = ST_PARITY_ERR;
                                end
                            end
                            BIT_STOP:
                            begin
                                restart = 1'b1;
                                if (!head.data_bit)
                                begin
                                    status = ST_STOP_ERR;
                                end
                                else
                                begin
                                    wr_en                    = 1'b1;
                                    wr_data                  = incoming_next;
                                    wr_slot_next             = wr_slot_inc;
                                    unread_next[wr_slot_inc] = 1'b1;
                                    status                   = ST_STORED;
                                end
                            end
                            default: restart = 1'b1;
                        endcase
                    end
                    else
                    begin
                        idx_n          = bit_index_reg + 4'd1;
                        bit_index_next = idx_n;
                        data_pos       = 3'(idx_n - BIT_DATA_FIRST);
                        tx_bit         = outgoing_reg[data_pos];
                        case (idx_n) inside
                            BIT_START: level_next = LVL_LOW;
                            [BIT_DATA_FIRST:BIT_DATA_LAST]:
                            begin
                                level_next  = tx_bit ? LVL_HIGH : LVL_LOW;
                                parity_next = parity_reg ^ tx_bit;
                            end
                            BIT_PARITY: level_next = parity_reg ? LVL_LOW : LVL_HIGH;
                            BIT_STOP:   level_next = LVL_RELEASED;
                            default:
                            begin
                                level_next = LVL_RELEASED;
                                restart    = 1'b1;
                                status     = ST_SEND_DONE;
                            end
                        endcase
                    end
                end
                ACT_TICK:
                begin
                    if (gap_reg != GAP_MAX)
                    begin
                        gap_next = gap_reg + 16'd1;
                    end
                end
                ACT_POP:
                begin
                    if (unread_reg[rd_slot_inc])
                    begin
                        unread_next[rd_slot_inc] = 1'b0;
                        rd_slot_next             = rd_slot_inc;
                        rd_en                    = 1'b1;
                        code_valid               = 1'b1;
                    end
                end
                ACT_SEND:
                begin
                    restart = 1'b1;
                end
                default: ;
            endcase
        end

        if (restart)
        begin
            bit_index_next = 4'd0;
            incoming_next  = 8'd0;
            outgoing_next  = 8'd0;
            parity_next    = 1'b0;
            gap_next       = 16'd0;
            rx_mode_next   = 1'b1;
        end

        // send: load byte and request the line
        if (exec && head.action == ACT_SEND)
        begin
            rx_mode_next  = 1'b0;
            outgoing_next = head.send_byte;
            level_next    = LVL_LOW;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_index_reg <= 4'd0;
            incoming_reg  <= 8'd0;
            outgoing_reg  <= 8'd0;
            parity_reg    <= 1'b0;
            gap_reg       <= 16'd0;
            rx_mode_reg   <= 1'b1;
            level_reg     <= LVL_RELEASED;
            unread_reg    <= '0;
            wr_slot_reg   <= '0;
            rd_slot_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            bit_index_reg <= bit_index_next;
            incoming_reg  <= incoming_next;
            outgoing_reg  <= outgoing_next;
            parity_reg    <= parity_next;
            gap_reg       <= gap_next;
            rx_mode_reg   <= rx_mode_next;
            level_reg     <= level_next;
            unread_reg    <= unread_next;
            wr_slot_reg   <= wr_slot_next;
            rd_slot_reg   <= rd_slot_next;
            if (exec)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_slot_inc] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q <= ring_mem[rd_slot_inc];
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            drive_reg      <= (level_next == LVL_HIGH);
            enable_reg     <= (level_next != LVL_RELEASED);
            tx_reg         <= !rx_mode_next;
            code_valid_reg <= code_valid;
            status_reg     <= status;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.data_drive     = drive_reg;
    assign rsp.data_enable    = enable_reg;
    assign rsp.transmitting   = tx_reg;
    assign rsp.scancode       = code_valid_reg ? mem_q : 8'd0;
    assign rsp.scancode_valid = code_valid_reg;
    assign rsp.frame_status   = status_reg;

endmodule

`default_nettype wire

/* design/ps2_host_link_with_scancode_fifo.sv */
// ----------------------------------------------------------------------------
// PS/2 host link with scancode ring
// Host side of a PS/2 keyboard link stepped by clock-edge, tick, pop and send
// items, with an APB register for the inter-edge gap timeout.
// ----------------------------------------------------------------------------
// Every command item gives exactly one result item. The link takes one item
// per clock cycle, sustained, while the result channel does not stall it.
// A command passes from the head of the two-entry command queue, where the
// link engine works it out, into the engine's result register, which
// latches it together with the scancode ring's registered read port. With
// the result stalled, the queue fills both its entries before the input
// stalls. The ring's unread flags are flip-flops cleared by reset, so no
// clearing pass is needed and the link is ready straight out of reset.
// A popped slot's byte comes from the ring memory and reads 0 when nothing
// is unread. gap_timeout_ticks sits at byte address 0 and resets to 250.
`default_nettype none

module ps2_host_link_with_scancode_fifo #(
    parameter int RING_DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    ps2hl_cmd_if.sink                              cmd,
    ps2hl_rsp_if.source                            rsp,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [ps2hl_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    import ps2hl_pkg::*;

    logic [15:0] gap_timeout_reg;
    logic        push;
    cmd_t        push_cmd;
    cmd_t        head;
    q_status_t   q_status;
    logic        pop;
    logic        reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == REG_GAP_TIMEOUT);
    assign prdata  = reg_hit ? {16'd0, gap_timeout_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_timeout_reg <= GAP_TIMEOUT_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            gap_timeout_reg <= pwdata[15:0];
        end
    end

    ps2hl_front u_front (
        .cmd      (cmd),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    ps2hl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    ps2hl_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_status    (q_status),
        .gap_timeout (gap_timeout_reg),
        .pop         (pop),
        .rsp         (rsp)
    );

endmodule

`default_nettype wire

/* design/ps2hl_checker.sv */
// ----------------------------------------------------------------------------
// PS/2 host link port checker
// Concurrent checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ps2_host_link_with_scancode_fifo_macros.svh"

module ps2hl_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rsp_valid,
    input  logic       rsp_ready,
    input  logic       data_drive,
    input  logic       data_enable,
    input  logic       transmitting,
    input  logic [7:0] scancode,
    input  logic       scancode_valid,
    input  logic [2:0] frame_status
);
    import ps2hl_pkg::*;

    `PS2HL_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable({data_drive, data_enable, transmitting, scancode, scancode_valid, frame_status}), "result changed while stalled")
    `PS2HL_ASSERT_IMP(a_empty_pop_zero, clk, rst_n, rsp_valid && !scancode_valid, scancode == 8'd0, "scancode without valid")
    `PS2HL_ASSERT_IMP(a_rx_released, clk, rst_n, rsp_valid && !transmitting, !data_enable && !data_drive, "line driven in receive mode")
    `PS2HL_ASSERT_IMP(a_send_done, clk, rst_n, rsp_valid && frame_status == ST_SEND_DONE, !transmitting && !scancode_valid, "send done while still sending")

endmodule

bind ps2_host_link_with_scancode_fifo ps2hl_checker u_ps2hl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .data_drive     (rsp.data_drive),
    .data_enable    (rsp.data_enable),
    .transmitting   (rsp.transmitting),
    .scancode       (rsp.scancode),
    .scancode_valid (rsp.scancode_valid),
    .frame_status   (rsp.frame_status)
);

`default_nettype wire

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// PS/2 host link testbench
// Drives edge, tick, pop and send items through the command channel under
// random idling on both sides. It predicts each result item from its own
// model of the receive and transmit frame logic and the scancode ring, and
// checks every result field. The gap timeout register is exercised across
// four settings: the reset value, 1, 65534 and a random value from 2 to 12.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ps2hl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RING_SLOTS  = 16;

    typedef struct packed {
        logic       data_drive;
        logic       data_enable;
        logic       transmitting;
        logic [7:0] scancode;
        logic       scancode_valid;
        logic [2:0] frame_status;
    } link_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    ps2hl_cmd_if cmd_ch ();
    ps2hl_rsp_if rsp_ch ();

    ps2_host_link_with_scancode_fifo dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 clk = ~clk;

    // link model state
    logic [15:0] gap_limit;
    logic [3:0]  bit_pos;
    logic [7:0]  rx_byte;
    logic [7:0]  tx_byte;
    logic        par_acc;
    logic [15:0] gap_cnt;
    logic        rx_mode;
    level_t      line_lvl;
    logic [7:0]  ring_data [RING_SLOTS];
    logic        ring_flag [RING_SLOTS];
    logic [3:0]  wr_slot;
    logic [3:0]  rd_slot;

    cmd_t         pending_cmds [$];
    link_result_t expected_results [$];

    int  n_queued;
    int  n_accepted;
    int  n_checked;
    int  n_fail;
    int  n_stored;
    int  n_sent;
    int  n_frame_err;
    int  n_popped;
    int  cycles;
    int  hold_left;
    logic hold_armed;
    logic steady;

    function automatic void restart_frame();
        bit_pos = '0;
        rx_byte = '0;
        tx_byte = '0;
        par_acc = 1'b0;
        gap_cnt = '0;
        rx_mode = 1'b1;
    endfunction

    function automatic void reset_link();
        gap_limit = GAP_TIMEOUT_RESET;
        restart_frame();
        line_lvl = LVL_RELEASED;
        for (int i = 0; i < RING_SLOTS; i++)
        begin
            ring_data[i] = '0;
            ring_flag[i] = 1'b0;
        end
        wr_slot = '0;
        rd_slot = '0;
    endfunction

    function automatic logic [2:0] rx_edge(input logic din);
        if (gap_cnt > gap_limit)
            restart_frame();
        gap_cnt = '0;
        bit_pos = bit_pos + 4'd1;
        if (bit_pos == BIT_START)
        begin
            if (din)
            begin
                restart_frame();
                return ST_START_ERR;
            end
        end
        else if (bit_pos >= BIT_DATA_FIRST && bit_pos <= BIT_DATA_LAST)
        begin
            rx_byte[3'(bit_pos - BIT_DATA_FIRST)] = din;
            par_acc ^= din;
        end
        else if (bit_pos == BIT_PARITY)
        begin
            if (din == par_acc)
            begin
                restart_frame();
                return ST_PARITY_ERR;
            end
        end
        else if (bit_pos == BIT_STOP)
        begin
            if (!din)
            begin
                restart_frame();
                return ST_STOP_ERR;
            end
            wr_slot = wr_slot + 4'd1;
            ring_data[wr_slot] = rx_byte;
            ring_flag[wr_slot] = 1'b1;
            restart_frame();
            return ST_STORED;
        end
        else
            restart_frame();
        return ST_NONE;
    endfunction

    function automatic logic [2:0] tx_edge();
        logic b;
        bit_pos = bit_pos + 4'd1;
        if (bit_pos == BIT_START)
            line_lvl = LVL_LOW;
        else if (bit_pos >= BIT_DATA_FIRST && bit_pos <= BIT_DATA_LAST)
        begin
            b = tx_byte[3'(bit_pos - BIT_DATA_FIRST)];
            line_lvl = b ? LVL_HIGH : LVL_LOW;
            par_acc ^= b;
        end
        else if (bit_pos == BIT_PARITY)
            line_lvl = par_acc ? LVL_LOW : LVL_HIGH;
        else if (bit_pos == BIT_STOP)
            line_lvl = LVL_RELEASED;
        else
        begin
            line_lvl = LVL_RELEASED;
            restart_frame();
            return ST_SEND_DONE;
        end
        return ST_NONE;
    endfunction

    function automatic link_result_t step_link(input cmd_t c);
        link_result_t r;
        logic [3:0] nxt;
        r = '0;
        case (c.action)
            ACT_EDGE: r.frame_status = rx_mode ? rx_edge(c.data_bit) : tx_edge();
            ACT_TICK:
                if (gap_cnt != GAP_MAX)
                    gap_cnt = gap_cnt + 16'd1;
            ACT_POP:
            begin
                nxt = rd_slot + 4'd1;
                if (ring_flag[nxt])
                begin
                    ring_flag[nxt] = 1'b0;
                    rd_slot = nxt;
                    r.scancode = ring_data[nxt];
                    r.scancode_valid = 1'b1;
                    n_popped++;
                end
            end
            default:
            begin
                restart_frame();
                rx_mode = 1'b0;
                tx_byte = c.send_byte;
                line_lvl = LVL_LOW;
            end
        endcase
        r.data_drive = (line_lvl == LVL_HIGH);
        r.data_enable = (line_lvl != LVL_RELEASED);
        r.transmitting = !rx_mode;
        if (r.frame_status == ST_STORED)
            n_stored++;
        else if (r.frame_status == ST_SEND_DONE)
            n_sent++;
        else if (r.frame_status != ST_NONE)
            n_frame_err++;
        return r;
    endfunction

    // command side
    always @(posedge clk)
    begin : drive_cmd
        cmd_t cur;
        cmd_t nxt;
        if (!rst_n)
            cmd_ch.valid <= 1'b0;
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                cur.action = action_t'(cmd_ch.action);
                cur.data_bit = cmd_ch.data_bit;
                cur.send_byte = cmd_ch.send_byte;
                expected_results.push_back(step_link(cur));
                n_accepted++;
            end
            if (cmd_ch.valid && !cmd_ch.ready)
                ;
            else if (pending_cmds.size() != 0 && (steady || $urandom_range(0, 99) >= 24))
            begin
                nxt = pending_cmds.pop_front();
                cmd_ch.valid <= 1'b1;
                cmd_ch.action <= nxt.action;
                cmd_ch.data_bit <= nxt.data_bit;
                cmd_ch.send_byte <= nxt.send_byte;
            end
            else
                cmd_ch.valid <= 1'b0;
        end
    end

    // long receiver hold-off, once, so the command queue backs up
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_armed <= 1'b1;
        end
        else if (hold_armed && n_accepted >= 120)
        begin
            hold_left <= 80;
            hold_armed <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endtask

    // result side
    always @(posedge clk)
    begin : watch_rsp
        link_result_t want;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result item with nothing expected");
                    n_fail++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("data_drive", want.data_drive, rsp_ch.data_drive);
                    check_field("data_enable", want.data_enable, rsp_ch.data_enable);
                    check_field("transmitting", want.transmitting, rsp_ch.transmitting);
                    check_field("scancode", want.scancode, rsp_ch.scancode);
                    check_field("scancode_valid", want.scancode_valid,
                                rsp_ch.scancode_valid);
                    check_field("frame_status", want.frame_status, rsp_ch.frame_status);
                    n_checked++;
                end
            end
            rsp_ch.ready <= (hold_left == 0) && (steady || $urandom_range(0, 99) >= 24);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic apb_access(input logic wr, input logic [15:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {REG_GAP_TIMEOUT, 2'b00};
        pwdata <= {16'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (!wr && prdata[15:0] != val)
        begin
            $error("gap_timeout_ticks: expected %0d, got %0d", val, prdata[15:0]);
            n_fail++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_gap_limit(input logic [15:0] val);
        apb_access(1'b1, val);
        gap_limit = val;
        apb_access(1'b0, val);
    endtask

    task automatic queue_item(input action_t a, input logic d, input logic [7:0] v);
        cmd_t c;
        c.action = a;
        c.data_bit = d;
        c.send_byte = v;
        pending_cmds.push_back(c);
        n_queued++;
    endtask

    task automatic queue_gap();
        int n;
        n = 0;
        if (gap_limit <= 16'd20 && $urandom_range(0, 29) == 0)
            n = gap_limit + $urandom_range(1, 2);
        else if ($urandom_range(0, 3) == 0)
            n = $urandom_range(1, (gap_limit < 16'd3) ? gap_limit : 3);
        for (int i = 0; i < n; i++)
            queue_item(ACT_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endtask

    // fault: 0 clean, 1 start bit high, 2 parity wrong, 3 stop bit low
    task automatic queue_rx_frame(input logic [7:0] v, input int fault, input logic exact);
        logic [10:0] bits;
        int len;
        bits = {1'(fault != 3), (~^v) ^ 1'(fault == 2), v, 1'(fault == 1)};
        len = (fault == 1) ? 1 : 11;
        if (!exact && $urandom_range(0, 19) == 0)
            len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++)
        begin
            if (!exact)
                queue_gap();
            queue_item(ACT_EDGE, bits[i], 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic queue_tx(input logic [7:0] v, input logic exact);
        int n;
        queue_item(ACT_SEND, 1'($urandom_range(0, 1)), v);
        n = (!exact && $urandom_range(0, 9) == 0) ? $urandom_range(0, 11) : 12;
        for (int i = 0; i < n; i++)
        begin
            if (!exact && $urandom_range(0, 7) == 0)
                queue_item($urandom_range(0, 1) ? ACT_TICK : ACT_POP,
                           1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            queue_item(ACT_EDGE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic queue_pops(input int n);
        for (int i = 0; i < n; i++)
            queue_item(ACT_POP, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endtask

    task automatic queue_mix(input int target);
        int r;
        while (n_queued < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                queue_rx_frame(8'($urandom_range(0, 255)), 0, 1'b0);
            else if (r < 52)
                queue_rx_frame(8'($urandom_range(0, 255)), 2, 1'b0);
            else if (r < 58)
                queue_rx_frame(8'($urandom_range(0, 255)), 3, 1'b0);
            else if (r < 62)
                queue_rx_frame(8'($urandom_range(0, 255)), 1, 1'b0);
            else if (r < 74)
                queue_tx(8'($urandom_range(0, 255)), 1'b0);
            else if (r < 88)
                queue_pops($urandom_range(1, 5));
            else
                repeat ($urandom_range(1, 3))
                    queue_item(action_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                               8'($urandom_range(0, 255)));
        end
        queue_pops(20);
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || expected_results.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.action = ACT_TICK;
        cmd_ch.data_bit = 1'b0;
        cmd_ch.send_byte = '0;
        rsp_ch.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        steady = 1'b0;
        reset_link();
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pop, all-zero byte, bad start, pop, all-ones send
        queue_item(ACT_POP, 1'b1, 8'hFF);
        queue_rx_frame(8'h00, 0, 1'b1);
        queue_rx_frame(8'h00, 1, 1'b1);
        queue_item(ACT_POP, 1'b0, 8'h00);
        queue_tx(8'hFF, 1'b1);
        queue_mix(240);
        wait_drained();

        set_gap_limit(16'd1);
        queue_mix(n_queued + 130);
        wait_drained();

        steady = 1'b1;
        set_gap_limit(16'd65534);
        queue_mix(n_queued + 130);
        wait_drained();
        steady = 1'b0;

        set_gap_limit(16'($urandom_range(2, 12)));
        queue_mix(n_queued + 130);
        wait_drained();

        $display("covered %0d items over four gap timeout settings: %0d bytes stored, %0d popped",
                 n_accepted, n_stored, n_popped);
        $display("%0d sends completed, %0d framing errors, %0d results checked",
                 n_sent, n_frame_err, n_checked);
        if (n_fail == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/ps2hl_pkg.sv
design/ps2hl_if.sv
design/ps2hl_front.sv
design/ps2hl_queue.sv
design/ps2hl_back.sv
design/ps2_host_link_with_scancode_fifo.sv
design/ps2hl_checker.sv
tb/sv/tb.sv
